@@ hdl/slu_pkg.sv @@
// types, codes and helpers shared by the serial line unit register block
package slu_pkg;

   // request kinds
   localparam logic [2:0] MODE_READ  = 3'd0;
   localparam logic [2:0] MODE_WRITE = 3'd1;
   localparam logic [2:0] MODE_TICK  = 3'd2;
   localparam logic [2:0] MODE_ACK   = 3'd3;
   localparam logic [2:0] MODE_CHAIN = 3'd4;

   // register selects, address bits 2:1
   localparam logic [1:0] SEL_RX_CSR = 2'd0;
   localparam logic [1:0] SEL_RX_BUF = 2'd1;
   localparam logic [1:0] SEL_TX_CSR = 2'd2;
   localparam logic [1:0] SEL_TX_BUF = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CFG_RCV_VEC    = 2'd0;
   localparam logic [1:0] CFG_XMT_VEC    = 2'd1;
   localparam logic [1:0] CFG_CHAR_TICKS = 2'd2;

   localparam int CFG_DATA_WIDTH = 24;

   localparam logic [15:0] RCV_VEC_RESET    = 16'o60;
   localparam logic [15:0] XMT_VEC_RESET    = 16'o64;
   localparam logic [23:0] CHAR_TICKS_RESET = 24'd1000;

   // status bit positions
   localparam int RDY_POS  = 7;
   localparam int IEN_POS  = 6;
   localparam int LOOP_POS = 2;
   localparam int BRK_POS  = 0;
   localparam int OVR_POS  = 12;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  reg_address;
      logic        byte_access;
      logic [15:0] write_data;
      logic [15:0] tick_count;
      logic [15:0] ack_vector;
      logic        offer_valid;
      logic [7:0]  offer_byte;
      logic        offer_is_script;
      logic        chain_request_n;
      logic [15:0] chain_vector;
   } slu_req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        offer_taken;
      logic        irq_line_n;
      logic [15:0] irq_vector;
      logic        irq_restart;
   } slu_rsp_type;

   typedef struct packed {
      logic        rx_done_flag;
      logic        rx_int_enable;
      logic        rx_overrun_flag;
      logic [7:0]  rx_data_reg;
      logic        tx_done_flag;
      logic        tx_int_enable;
      logic        loopback_mode;
      logic        break_bit;
      logic [7:0]  tx_data_reg;
      logic        tx_busy_flag;
      logic        rx_irq_pending;
      logic        tx_irq_pending;
      logic [15:0] offered_vector;
   } slu_state_type;

   localparam slu_state_type STATE_RESET = '{
      rx_done_flag:    1'b0,
      rx_int_enable:   1'b0,
      rx_overrun_flag: 1'b0,
      rx_data_reg:     8'h00,
      tx_done_flag:    1'b1,
      tx_int_enable:   1'b0,
      loopback_mode:   1'b0,
      break_bit:       1'b0,
      tx_data_reg:     8'h00,
      tx_busy_flag:    1'b0,
      rx_irq_pending:  1'b0,
      tx_irq_pending:  1'b0,
      offered_vector:  16'h0000
   };

   // receive beats transmit, both beat the downstream chain
   function automatic logic [15:0] irq_pick(input logic rx_pend, input logic tx_pend,
                                            input logic chain_n, input logic [15:0] chain_v,
                                            input logic [15:0] rx_v, input logic [15:0] tx_v);
      logic [15:0] v;
      if (rx_pend) begin
         v = rx_v;
      end else if (tx_pend) begin
         v = tx_v;
      end else if (!chain_n) begin
         v = chain_v;
      end else begin
         v = 16'h0000;
      end
      return v;
   endfunction

   // line released and reasserted when the vector moves to a new nonzero value
   function automatic logic irq_moved(input logic [15:0] old_v, input logic [15:0] new_v);
      return (new_v != old_v) && (new_v != 16'h0000);
   endfunction

endpackage

@@ hdl/serial_line_unit_registers_unit.sv @@
// top level of the serial line unit register block: request, state and response registers
//
//   channel   direction  handshake                 payload
//   req_*     in         req_valid / req_stall     mode, address, data, tick, ack, offer, chain
//   rsp_*     out        rsp_valid / rsp_stall     read data, tx char, offer taken, irq
//   csr_*     in         csr_write_enable          csr_index, csr_wdata
//
// one request per cycle sustained while rsp_stall stays low; an accepted request
// sits in the input register while the step logic runs, and the response register
// loads from it once the response slot is free
// reset (synchronous, active high) clears flags except transmitter done, which it
// sets, clears countdowns and offered vector, and loads the vector and character
// time registers with their defaults; a stalled response holds the response
// register; the input register keeps filling until it too is full, then req_stall rises
module serial_line_unit_registers_unit import slu_pkg::*; #(
   parameter int COUNTDOWN_WIDTH = 26
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_mode,
   input  logic [2:0]                 req_reg_address,
   input  logic                       req_byte_access,
   input  logic [15:0]                req_write_data,
   input  logic [15:0]                req_tick_count,
   input  logic [15:0]                req_ack_vector,
   input  logic                       req_offer_valid,
   input  logic [7:0]                 req_offer_byte,
   input  logic                       req_offer_is_script,
   input  logic                       req_chain_request_n,
   input  logic [15:0]                req_chain_vector,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [15:0]                rsp_read_data,
   output logic                       rsp_tx_valid,
   output logic [7:0]                 rsp_tx_byte,
   output logic                       rsp_offer_taken,
   output logic                       rsp_irq_line_n,
   output logic [15:0]                rsp_irq_vector,
   output logic                       rsp_irq_restart,
   // configuration writes
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_index,
   input  logic [CFG_DATA_WIDTH-1:0]  csr_wdata
);

   // configuration registers
   logic [15:0] rcv_vec_ff;
   logic [15:0] xmt_vec_ff;
   logic [23:0] char_ticks_ff;

   // input register
   logic        req_valid_ff;
   slu_req_type req_ff;
   slu_req_type req_in;

   // device state
   slu_state_type               state_ff;
   slu_state_type               state_in;
   logic [COUNTDOWN_WIDTH-1:0]  tx_cd_ff;
   logic [COUNTDOWN_WIDTH-1:0]  tx_cd_in;
   logic [COUNTDOWN_WIDTH-1:0]  rx_cd_ff;
   logic [COUNTDOWN_WIDTH-1:0]  rx_cd_in;

   // response register
   logic        rsp_valid_ff;
   slu_rsp_type rsp_ff;
   slu_rsp_type rsp_in;

   logic req_take;
   logic step_go;

   // the step runs when the held request can move into a free response slot
   assign step_go   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !step_go;
   assign req_take  = req_valid && !req_stall;

   assign req_in = '{
      mode:            req_mode,
      reg_address:     req_reg_address,
      byte_access:     req_byte_access,
      write_data:      req_write_data,
      tick_count:      req_tick_count,
      ack_vector:      req_ack_vector,
      offer_valid:     req_offer_valid,
      offer_byte:      req_offer_byte,
      offer_is_script: req_offer_is_script,
      chain_request_n: req_chain_request_n,
      chain_vector:    req_chain_vector
   };

   slu_step #(
      .COUNTDOWN_WIDTH(COUNTDOWN_WIDTH)
   ) u_step (
      .req        (req_ff),
      .st         (state_ff),
      .tx_cd      (tx_cd_ff),
      .rx_cd      (rx_cd_ff),
      .rcv_vec    (rcv_vec_ff),
      .xmt_vec    (xmt_vec_ff),
      .char_ticks (char_ticks_ff),
      .nxt        (state_in),
      .tx_cd_nxt  (tx_cd_in),
      .rx_cd_nxt  (rx_cd_in),
      .rsp        (rsp_in)
   );

   // configuration writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rcv_vec_ff    <= RCV_VEC_RESET;
         xmt_vec_ff    <= XMT_VEC_RESET;
         char_ticks_ff <= CHAR_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CFG_RCV_VEC:    rcv_vec_ff    <= csr_wdata[15:0];
            CFG_XMT_VEC:    xmt_vec_ff    <= csr_wdata[15:0];
            CFG_CHAR_TICKS: char_ticks_ff <= csr_wdata[23:0];
            default: begin
            end
         endcase
      end
   end

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (step_go) begin
         req_valid_ff <= 1'b0;
      end
   end

   // input payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
   end

   // device state advances once per stepped request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         tx_cd_ff <= '0;
         rx_cd_ff <= '0;
      end else if (step_go) begin
         state_ff <= state_in;
         tx_cd_ff <= tx_cd_in;
         rx_cd_ff <= rx_cd_in;
      end
   end

   // response register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (step_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_tx_valid    = rsp_ff.tx_valid;
   assign rsp_tx_byte     = rsp_ff.tx_byte;
   assign rsp_offer_taken = rsp_ff.offer_taken;
   assign rsp_irq_line_n  = rsp_ff.irq_line_n;
   assign rsp_irq_vector  = rsp_ff.irq_vector;
   assign rsp_irq_restart = rsp_ff.irq_restart;

   // idle transmitter holds no leftover count
   a_tx_idle_count: assert property (@(posedge clock) disable iff (reset)
      !state_ff.tx_busy_flag |-> (tx_cd_ff == '0))
      else $error("tx countdown nonzero while transmitter idle");

   // busy and done are exclusive
   a_tx_busy_done: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.tx_busy_flag && state_ff.tx_done_flag))
      else $error("transmitter busy and done together");

   // receive request needs enable and done
   a_rx_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff.rx_irq_pending |-> (state_ff.rx_int_enable && state_ff.rx_done_flag))
      else $error("receive request without enable and done");

   // a taken byte leaves the receiver full
   a_offer_done: assert property (@(posedge clock) disable iff (reset)
      (step_go && rsp_in.offer_taken) |=> state_ff.rx_done_flag)
      else $error("offered byte taken but receiver not done");

   // line level agrees with the offered vector
   a_irq_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.irq_line_n == (rsp_ff.irq_vector == 16'h0000)))
      else $error("irq line disagrees with offered vector");

endmodule

@@ hdl/slu_step.sv @@
// combinational step logic: one request against the current register state
module slu_step import slu_pkg::*; #(
   parameter int COUNTDOWN_WIDTH = 26
) (
   input  slu_req_type                 req,
   input  slu_state_type               st,
   input  logic [COUNTDOWN_WIDTH-1:0]  tx_cd,
   input  logic [COUNTDOWN_WIDTH-1:0]  rx_cd,
   input  logic [15:0]                 rcv_vec,
   input  logic [15:0]                 xmt_vec,
   input  logic [23:0]                 char_ticks,
   output slu_state_type               nxt,
   output logic [COUNTDOWN_WIDTH-1:0]  tx_cd_nxt,
   output logic [COUNTDOWN_WIDTH-1:0]  rx_cd_nxt,
   output slu_rsp_type                 rsp
);

   localparam int CW = COUNTDOWN_WIDTH;
   localparam int LW = (CW > 24) ? CW : 24;

   logic [LW-1:0] ticks_ext;
   logic [LW-1:0] max_ext;
   logic [CW-1:0] load_val;

   // saturating subtract of elapsed ticks
   function automatic logic [CW-1:0] cd_sub(input logic [CW-1:0] left, input logic [15:0] n);
      logic [CW-1:0] n_ext;
      n_ext = CW'(n);
      return (left > n_ext) ? (left - n_ext) : '0;
   endfunction

   assign ticks_ext = LW'(char_ticks);
   assign max_ext   = LW'({CW{1'b1}});
   assign load_val  = (ticks_ext > max_ext) ? {CW{1'b1}} : ticks_ext[CW-1:0];

   logic [1:0]  sel;
   logic [15:0] word;
   logic [15:0] wval;
   logic [15:0] cand;
   logic        recompute;
   logic        restart;

   always_comb begin
      nxt       = st;
      tx_cd_nxt = tx_cd;
      rx_cd_nxt = rx_cd;
      rsp       = '0;
      sel       = req.reg_address[2:1];
      word      = 16'h0000;
      wval      = req.write_data;
      cand      = 16'h0000;
      recompute = 1'b0;
      restart   = 1'b0;

      case (req.mode)
         MODE_READ: begin
            case (sel)
               SEL_RX_CSR: begin
                  word[RDY_POS] = st.rx_done_flag;
                  word[IEN_POS] = st.rx_int_enable;
                  word[OVR_POS] = st.rx_overrun_flag;
               end
               SEL_RX_BUF: begin
                  word                = {8'h00, st.rx_data_reg};
                  nxt.rx_done_flag    = 1'b0;
                  nxt.rx_overrun_flag = 1'b0;
                  nxt.rx_irq_pending  = 1'b0;
                  recompute           = 1'b1;
               end
               SEL_TX_CSR: begin
                  word[RDY_POS]  = st.tx_done_flag;
                  word[IEN_POS]  = st.tx_int_enable;
                  word[LOOP_POS] = st.loopback_mode;
                  word[BRK_POS]  = st.break_bit;
               end
               default: begin
                  word = 16'h0000;
               end
            endcase
            if (req.byte_access) begin
               rsp.read_data = req.reg_address[0] ? {8'h00, word[15:8]} : {8'h00, word[7:0]};
            end else begin
               rsp.read_data = word;
            end
         end

         MODE_WRITE: begin
            if (req.byte_access) begin
               wval = req.reg_address[0] ? {req.write_data[7:0], 8'h00}
                                         : {8'h00, req.write_data[7:0]};
            end
            case (sel)
               SEL_RX_CSR: begin
                  nxt.rx_int_enable = wval[IEN_POS];
                  if (!wval[IEN_POS]) begin
                     nxt.rx_irq_pending = 1'b0;
                  end else if (!st.rx_int_enable && st.rx_done_flag) begin
                     nxt.rx_irq_pending = 1'b1;
                  end
                  recompute = 1'b1;
               end
               SEL_TX_CSR: begin
                  nxt.tx_int_enable = wval[IEN_POS];
                  nxt.loopback_mode = wval[LOOP_POS];
                  nxt.break_bit     = wval[BRK_POS];
                  if (!wval[IEN_POS]) begin
                     nxt.tx_irq_pending = 1'b0;
                  end else if (!st.tx_int_enable && st.tx_done_flag) begin
                     nxt.tx_irq_pending = 1'b1;
                  end
                  recompute = 1'b1;
               end
               SEL_TX_BUF: begin
                  nxt.tx_data_reg    = wval[7:0];
                  nxt.tx_done_flag   = 1'b0;
                  nxt.tx_irq_pending = 1'b0;
                  nxt.tx_busy_flag   = 1'b1;
                  tx_cd_nxt          = load_val;
                  recompute          = 1'b1;
               end
               default: begin
                  recompute = 1'b0;
               end
            endcase
         end

         MODE_TICK: begin
            // transmitter character time
            if (st.tx_busy_flag) begin
               tx_cd_nxt = cd_sub(tx_cd, req.tick_count);
               if (tx_cd_nxt == '0) begin
                  nxt.tx_busy_flag = 1'b0;
                  if (st.loopback_mode) begin
                     if (nxt.rx_done_flag) begin
                        nxt.rx_overrun_flag = 1'b1;
                     end else begin
                        nxt.rx_data_reg  = st.tx_data_reg;
                        nxt.rx_done_flag = 1'b1;
                        if (nxt.rx_int_enable) begin
                           nxt.rx_irq_pending = 1'b1;
                        end
                        cand = irq_pick(nxt.rx_irq_pending, nxt.tx_irq_pending,
                                        req.chain_request_n, req.chain_vector,
                                        rcv_vec, xmt_vec);
                        restart = restart | irq_moved(nxt.offered_vector, cand);
                        nxt.offered_vector = cand;
                     end
                  end else begin
                     rsp.tx_valid = 1'b1;
                     rsp.tx_byte  = st.tx_data_reg;
                  end
                  nxt.tx_done_flag = 1'b1;
                  if (nxt.tx_int_enable) begin
                     nxt.tx_irq_pending = 1'b1;
                  end
                  cand = irq_pick(nxt.rx_irq_pending, nxt.tx_irq_pending,
                                  req.chain_request_n, req.chain_vector,
                                  rcv_vec, xmt_vec);
                  restart = restart | irq_moved(nxt.offered_vector, cand);
                  nxt.offered_vector = cand;
               end
            end
            // receiver samples the line once per character time
            if (rx_cd != '0) begin
               rx_cd_nxt = cd_sub(rx_cd, req.tick_count);
            end else if (!nxt.rx_done_flag) begin
               rx_cd_nxt = load_val;
               if (req.offer_valid && (req.offer_is_script || !nxt.loopback_mode)) begin
                  nxt.rx_data_reg  = req.offer_byte;
                  nxt.rx_done_flag = 1'b1;
                  if (nxt.rx_int_enable) begin
                     nxt.rx_irq_pending = 1'b1;
                  end
                  cand = irq_pick(nxt.rx_irq_pending, nxt.tx_irq_pending,
                                  req.chain_request_n, req.chain_vector,
                                  rcv_vec, xmt_vec);
                  restart = restart | irq_moved(nxt.offered_vector, cand);
                  nxt.offered_vector = cand;
                  rsp.offer_taken    = 1'b1;
               end
            end
         end

         MODE_ACK: begin
            if (req.ack_vector != 16'h0000) begin
               if (req.ack_vector == rcv_vec) begin
                  nxt.rx_irq_pending = 1'b0;
               end
               if (req.ack_vector == xmt_vec) begin
                  nxt.tx_irq_pending = 1'b0;
               end
               recompute = 1'b1;
            end
         end

         MODE_CHAIN: begin
            recompute = 1'b1;
         end

         default: begin
            recompute = 1'b0;
         end
      endcase

      // single recompute for register, acknowledge and chain requests
      if (recompute) begin
         cand = irq_pick(nxt.rx_irq_pending, nxt.tx_irq_pending,
                         req.chain_request_n, req.chain_vector, rcv_vec, xmt_vec);
         restart = restart | irq_moved(nxt.offered_vector, cand);
         nxt.offered_vector = cand;
      end

      rsp.irq_vector  = nxt.offered_vector;
      rsp.irq_line_n  = (nxt.offered_vector == 16'h0000);
      rsp.irq_restart = restart;
   end

endmodule

@@ test/tb_serial_line_unit_registers_unit.sv @@
// testbench for the serial line unit register block: predictor, driver, monitor and checks
module tb_serial_line_unit_registers_unit;
   import slu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 23;
   // no idling on either side while the request count is in this window
   localparam int CALM_FROM   = 400;
   localparam int CALM_TO     = 600;
   // long receiver hold-off once this many responses have been checked
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 80;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [2:0]                req_mode = '0;
   logic [2:0]                req_reg_address = '0;
   logic                      req_byte_access = 1'b0;
   logic [15:0]               req_write_data = '0;
   logic [15:0]               req_tick_count = '0;
   logic [15:0]               req_ack_vector = '0;
   logic                      req_offer_valid = 1'b0;
   logic [7:0]                req_offer_byte = '0;
   logic                      req_offer_is_script = 1'b0;
   logic                      req_chain_request_n = 1'b1;
   logic [15:0]               req_chain_vector = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [15:0]               rsp_read_data;
   logic                      rsp_tx_valid;
   logic [7:0]                rsp_tx_byte;
   logic                      rsp_offer_taken;
   logic                      rsp_irq_line_n;
   logic [15:0]               rsp_irq_vector;
   logic                      rsp_irq_restart;

   logic                      csr_write_enable = 1'b0;
   logic [1:0]                csr_index = '0;
   logic [CFG_DATA_WIDTH-1:0] csr_wdata = '0;

   serial_line_unit_registers_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_reg_address     (req_reg_address),
      .req_byte_access     (req_byte_access),
      .req_write_data      (req_write_data),
      .req_tick_count      (req_tick_count),
      .req_ack_vector      (req_ack_vector),
      .req_offer_valid     (req_offer_valid),
      .req_offer_byte      (req_offer_byte),
      .req_offer_is_script (req_offer_is_script),
      .req_chain_request_n (req_chain_request_n),
      .req_chain_vector    (req_chain_vector),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_data       (rsp_read_data),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_offer_taken     (rsp_offer_taken),
      .rsp_irq_line_n      (rsp_irq_line_n),
      .rsp_irq_vector      (rsp_irq_vector),
      .rsp_irq_restart     (rsp_irq_restart),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // shadow of the block: configuration copy and register state
   // ---------------------------------------------------------------
   logic [15:0] cfg_rx_vec     = RCV_VEC_RESET;
   logic [15:0] cfg_tx_vec     = XMT_VEC_RESET;
   logic [23:0] cfg_char_ticks = CHAR_TICKS_RESET;

   logic        rcv_done  = 1'b0;
   logic        rcv_ien   = 1'b0;
   logic        rcv_ovr   = 1'b0;
   logic [7:0]  rcv_byte  = 8'h00;
   logic        xmt_done  = 1'b1;
   logic        xmt_ien   = 1'b0;
   logic        xmt_loop  = 1'b0;
   logic        xmt_brk   = 1'b0;
   logic [7:0]  xmt_byte  = 8'h00;
   logic        xmt_busy  = 1'b0;
   logic [25:0] xmt_left  = '0;
   logic [25:0] rcv_left  = '0;
   logic        rcv_pend  = 1'b0;
   logic        xmt_pend  = 1'b0;
   logic [15:0] irq_vec_now = 16'h0000;

   // chain inputs as seen by the current request, and the restart marker
   logic        chain_n_seen   = 1'b1;
   logic [15:0] chain_vec_seen = 16'h0000;
   logic        vec_moved      = 1'b0;

   // saturating subtract on a character countdown
   function automatic logic [25:0] tick_down(input logic [25:0] left, input logic [15:0] n);
      return (left > 26'(n)) ? left - 26'(n) : 26'd0;
   endfunction

   // receive first, then transmit, then whatever the chain asks for
   function void settle_vector();
      logic [15:0] v;
      if (rcv_pend) begin
         v = cfg_rx_vec;
      end else if (xmt_pend) begin
         v = cfg_tx_vec;
      end else if (!chain_n_seen) begin
         v = chain_vec_seen;
      end else begin
         v = 16'h0000;
      end
      if (v != irq_vec_now) begin
         if (v != 16'h0000) vec_moved = 1'b1;
         irq_vec_now = v;
      end
   endfunction

   // a byte reaching the receiver is lost if the last one was not read yet
   function void take_byte(input logic [7:0] b);
      if (rcv_done) begin
         rcv_ovr = 1'b1;
      end else begin
         rcv_byte = b;
         rcv_done = 1'b1;
         if (rcv_ien) rcv_pend = 1'b1;
         settle_vector();
      end
   endfunction

   function logic [15:0] read_reg(input logic [1:0] sel);
      logic [15:0] w;
      w = 16'h0000;
      case (sel)
         SEL_RX_CSR: begin
            w[RDY_POS] = rcv_done;
            w[IEN_POS] = rcv_ien;
            w[OVR_POS] = rcv_ovr;
         end
         SEL_RX_BUF: begin
            // reading the buffer clears done, overrun and the receive request
            w = {8'h00, rcv_byte};
            rcv_done = 1'b0;
            rcv_ovr  = 1'b0;
            rcv_pend = 1'b0;
            settle_vector();
         end
         SEL_TX_CSR: begin
            w[RDY_POS]  = xmt_done;
            w[IEN_POS]  = xmt_ien;
            w[LOOP_POS] = xmt_loop;
            w[BRK_POS]  = xmt_brk;
         end
         default: ;
      endcase
      return w;
   endfunction

   function void write_reg(input logic [1:0] sel, input logic [15:0] v);
      logic was;
      case (sel)
         SEL_RX_CSR: begin
            was = rcv_ien;
            rcv_ien = v[IEN_POS];
            if (!rcv_ien) rcv_pend = 1'b0;
            else if (!was && rcv_done) rcv_pend = 1'b1;
            settle_vector();
         end
         SEL_TX_CSR: begin
            was = xmt_ien;
            xmt_ien  = v[IEN_POS];
            xmt_loop = v[LOOP_POS];
            xmt_brk  = v[BRK_POS];
            if (!xmt_ien) xmt_pend = 1'b0;
            else if (!was && xmt_done) xmt_pend = 1'b1;
            settle_vector();
         end
         SEL_TX_BUF: begin
            // a 24-bit character time always fits the 26-bit countdown
            xmt_byte = v[7:0];
            xmt_done = 1'b0;
            xmt_pend = 1'b0;
            xmt_busy = 1'b1;
            xmt_left = 26'(cfg_char_ticks);
            settle_vector();
         end
         default: ;  // receive buffer writes are dropped
      endcase
   endfunction

   // one request in, the response it should produce out
   function slu_rsp_type slu_predict(input slu_req_type r);
      slu_rsp_type o;
      logic [15:0] w;
      logic [1:0]  sel;
      o = '0;
      sel = r.reg_address[2:1];
      chain_n_seen   = r.chain_request_n;
      chain_vec_seen = r.chain_vector;
      vec_moved      = 1'b0;
      case (r.mode)
         MODE_READ: begin
            w = read_reg(sel);
            if (r.byte_access) o.read_data = r.reg_address[0] ? {8'h00, w[15:8]} : {8'h00, w[7:0]};
            else o.read_data = w;
         end
         MODE_WRITE: begin
            // a high byte write leaves the low half zero
            if (r.byte_access) begin
               w = r.reg_address[0] ? {r.write_data[7:0], 8'h00} : {8'h00, r.write_data[7:0]};
            end else begin
               w = r.write_data;
            end
            write_reg(sel, w);
         end
         MODE_TICK: begin
            if (xmt_busy) begin
               xmt_left = tick_down(xmt_left, r.tick_count);
               if (xmt_left == 26'd0) begin
                  xmt_busy = 1'b0;
                  if (xmt_loop) begin
                     take_byte(xmt_byte);
                  end else begin
                     o.tx_valid = 1'b1;
                     o.tx_byte  = xmt_byte;
                  end
                  xmt_done = 1'b1;
                  if (xmt_ien) xmt_pend = 1'b1;
                  settle_vector();
               end
            end
            // receiver samples the line once per character time
            if (rcv_left != 26'd0) begin
               rcv_left = tick_down(rcv_left, r.tick_count);
            end else if (!rcv_done) begin
               rcv_left = 26'(cfg_char_ticks);
               if (r.offer_valid && (r.offer_is_script || !xmt_loop)) begin
                  take_byte(r.offer_byte);
                  o.offer_taken = 1'b1;
               end
            end
         end
         MODE_ACK: begin
            if (r.ack_vector != 16'h0000) begin
               if (r.ack_vector == cfg_rx_vec) rcv_pend = 1'b0;
               if (r.ack_vector == cfg_tx_vec) xmt_pend = 1'b0;
               settle_vector();
            end
         end
         MODE_CHAIN: settle_vector();
         default: ;  // unused modes leave everything alone
      endcase
      o.irq_line_n  = (irq_vec_now == 16'h0000);
      o.irq_vector  = irq_vec_now;
      o.irq_restart = vec_moved;
      return o;
   endfunction

   // ---------------------------------------------------------------
   // request building
   // ---------------------------------------------------------------
   function automatic slu_req_type mk(input logic [2:0] mode, input logic [2:0] addr,
                                      input logic byte_acc, input logic [15:0] value,
                                      input logic ofv, input logic ofs, input logic chn);
      slu_req_type r;
      r.mode            = mode;
      r.reg_address     = addr;
      r.byte_access     = byte_acc;
      r.write_data      = value;
      r.tick_count      = value;
      r.ack_vector      = value;
      r.offer_valid     = ofv;
      r.offer_byte      = 8'($urandom);
      r.offer_is_script = ofs;
      r.chain_request_n = chn;
      r.chain_vector    = value;
      return r;
   endfunction

   // mostly well-formed traffic: ticks sized to the character time, acks that
   // hit a live vector, reads that drain the receiver
   function automatic slu_req_type rand_req();
      slu_req_type r;
      int pick;
      int span;
      pick = $urandom_range(99);
      r.reg_address     = 3'($urandom_range(7));
      r.byte_access     = ($urandom_range(9) < 3);
      r.write_data      = 16'($urandom);
      r.offer_valid     = ($urandom_range(9) < 7);
      r.offer_byte      = 8'($urandom);
      r.offer_is_script = 1'($urandom);
      r.chain_request_n = ($urandom_range(9) < 7);
      r.chain_vector    = 16'($urandom);
      span = 2 * int'(cfg_char_ticks) + 2;
      if (span > 65535) span = 65535;
      if ($urandom_range(9) == 0) r.tick_count = 16'($urandom);
      else r.tick_count = 16'($urandom_range(span));
      case ($urandom_range(4))
         0: r.ack_vector = 16'h0000;
         1: r.ack_vector = cfg_rx_vec;
         2: r.ack_vector = cfg_tx_vec;
         3: r.ack_vector = r.chain_vector;
         default: r.ack_vector = 16'($urandom);
      endcase
      if (pick < 35) r.mode = MODE_TICK;
      else if (pick < 60) r.mode = MODE_READ;
      else if (pick < 83) r.mode = MODE_WRITE;
      else if (pick < 91) r.mode = MODE_ACK;
      else if (pick < 97) r.mode = MODE_CHAIN;
      else r.mode = 3'($urandom_range(5, 7));
      return r;
   endfunction

   // ---------------------------------------------------------------
   // bookkeeping
   // ---------------------------------------------------------------
   slu_req_type pending_requests[$];
   slu_rsp_type expected_responses[$];
   slu_req_type cur_req;
   slu_rsp_type want_rsp;
   slu_rsp_type next_rsp;

   int queued_count   = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int error_count    = 0;
   int chars_out      = 0;
   int offers_taken   = 0;
   int restarts_seen  = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int hold_seen      = 0;
   int cycle_count    = 0;

   // driver: present the next request, hold it while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            next_rsp = slu_predict(cur_req);
            expected_responses.insert(expected_responses.size(), next_rsp);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 &&
                ((accepted_count >= CALM_FROM && accepted_count < CALM_TO) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               cur_req = pending_requests[0];
               pending_requests.delete(0);
               req_mode            <= cur_req.mode;
               req_reg_address     <= cur_req.reg_address;
               req_byte_access     <= cur_req.byte_access;
               req_write_data      <= cur_req.write_data;
               req_tick_count      <= cur_req.tick_count;
               req_ack_vector      <= cur_req.ack_vector;
               req_offer_valid     <= cur_req.offer_valid;
               req_offer_byte      <= cur_req.offer_byte;
               req_offer_is_script <= cur_req.offer_is_script;
               req_chain_request_n <= cur_req.chain_request_n;
               req_chain_vector    <= cur_req.chain_vector;
               req_valid           <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // one long hold-off so the block backs up into req_stall
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) hold_seen <= hold_seen + 1;
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && hold_seen == HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
         end
      end
   end

   // monitor: compare each response with the oldest prediction, drive the stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want_rsp = expected_responses[0];
               expected_responses.delete(0);
               check_field("read_data",   want_rsp.read_data,   rsp_read_data);
               check_field("tx_valid",    16'(want_rsp.tx_valid),    16'(rsp_tx_valid));
               check_field("tx_byte",     16'(want_rsp.tx_byte),     16'(rsp_tx_byte));
               check_field("offer_taken", 16'(want_rsp.offer_taken), 16'(rsp_offer_taken));
               check_field("irq_line_n",  16'(want_rsp.irq_line_n),  16'(rsp_irq_line_n));
               check_field("irq_vector",  want_rsp.irq_vector,  rsp_irq_vector);
               check_field("irq_restart", 16'(want_rsp.irq_restart), 16'(rsp_irq_restart));
               chars_out     += int'(want_rsp.tx_valid);
               offers_taken  += int'(want_rsp.offer_taken);
               restarts_seen += int'(want_rsp.irq_restart);
            end
            checked_count++;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !(checked_count >= CALM_FROM && checked_count < CALM_TO) &&
                         ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   task automatic push_req(input slu_req_type r);
      pending_requests.insert(pending_requests.size(), r);
      queued_count++;
   endtask

   // all requests accepted and answered, then the two-stage pipe is left to drain
   task automatic wait_idle();
      wait (accepted_count == queued_count && checked_count == queued_count);
      repeat (4) @(posedge clock);
   endtask

   // config writes are to be made only while the block is idle; the block itself does not enforce it
   task automatic set_cfg(input logic [1:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CFG_RCV_VEC:    cfg_rx_vec = val[15:0];
         CFG_XMT_VEC:    cfg_tx_vec = val[15:0];
         CFG_CHAR_TICKS: cfg_char_ticks = val;
         default: ;
      endcase
   endtask

   task automatic set_all(input logic [15:0] rxv, input logic [15:0] txv,
                          input logic [23:0] ct);
      set_cfg(CFG_RCV_VEC, {8'h00, rxv});
      set_cfg(CFG_XMT_VEC, {8'h00, txv});
      set_cfg(CFG_CHAR_TICKS, ct);
   endtask

   initial begin
      logic [15:0] shared_vec;
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset configuration
      push_req(mk(MODE_READ,  3'd0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1)); // receiver status word
      push_req(mk(MODE_READ,  3'd4, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1)); // transmitter status, done
      push_req(mk(MODE_READ,  3'd5, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1)); // its high byte
      push_req(mk(MODE_READ,  3'd6, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1)); // transmit buffer reads zero
      push_req(mk(MODE_WRITE, 3'd4, 1'b0, 16'h0041, 1'b0, 1'b0, 1'b1)); // enable edge with done set
      push_req(mk(MODE_ACK,   3'd0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1)); // empty ack ignored
      push_req(mk(MODE_ACK,   3'd0, 1'b0, XMT_VEC_RESET, 1'b0, 1'b0, 1'b1));
      push_req(mk(MODE_WRITE, 3'd2, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b1)); // receive buffer write
      push_req(mk(MODE_WRITE, 3'd7, 1'b1, 16'h12A5, 1'b0, 1'b0, 1'b1)); // high byte to tx buffer
      push_req(mk(MODE_TICK,  3'd0, 1'b0, 16'hFFFF, 1'b1, 1'b0, 1'b1)); // char out, host byte in
      push_req(mk(MODE_READ,  3'd0, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1));
      push_req(mk(MODE_WRITE, 3'd0, 1'b0, 16'h0040, 1'b0, 1'b0, 1'b1)); // rx enable edge, done set
      push_req(mk(MODE_READ,  3'd2, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1)); // buffer read clears
      push_req(mk(MODE_WRITE, 3'd4, 1'b1, 16'h0045, 1'b0, 1'b0, 1'b1)); // loopback, break, enable
      push_req(mk(MODE_WRITE, 3'd6, 1'b0, 16'h00C3, 1'b0, 1'b0, 1'b1));
      push_req(mk(MODE_TICK,  3'd0, 1'b0, 16'hFFFF, 1'b1, 1'b0, 1'b1)); // looped byte received
      push_req(mk(MODE_WRITE, 3'd6, 1'b0, 16'h005A, 1'b0, 1'b0, 1'b1));
      push_req(mk(MODE_TICK,  3'd0, 1'b0, 16'hFFFF, 1'b1, 1'b0, 1'b1)); // looped byte overruns
      push_req(mk(MODE_READ,  3'd1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1)); // overrun in high byte
      push_req(mk(MODE_READ,  3'd2, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1));
      push_req(mk(MODE_TICK,  3'd0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1)); // host byte refused in loop
      push_req(mk(MODE_TICK,  3'd0, 1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1));
      push_req(mk(MODE_TICK,  3'd0, 1'b0, 16'h0001, 1'b1, 1'b1, 1'b1)); // injected byte taken
      push_req(mk(MODE_CHAIN, 3'd0, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0));
      push_req(mk(3'd5,       3'd3, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0)); // unused modes
      push_req(mk(3'd7,       3'd7, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0));
      wait_idle();

      // random phases over a spread of vector and character time settings
      set_all(16'($urandom), 16'($urandom), 24'd1);
      for (n = 0; n < 190; n++) push_req(rand_req());
      wait_idle();

      // zero character time: every tick finishes a pending character
      set_all(16'h0000, 16'hFFFF, 24'd0);
      for (n = 0; n < 160; n++) push_req(rand_req());
      wait_idle();

      set_all(16'hFFFF, 16'h0000, 24'd25);
      for (n = 0; n < 190; n++) push_req(rand_req());
      wait_idle();

      // one vector shared by receive and transmit, so one ack clears both
      shared_vec = 16'($urandom_range(1, 65535));
      set_all(shared_vec, shared_vec, 24'($urandom_range(1, 200)));
      for (n = 0; n < 200; n++) push_req(rand_req());
      wait_idle();

      set_all(16'($urandom), 16'($urandom), 24'd3);
      for (n = 0; n < 200; n++) push_req(rand_req());
      wait_idle();

      // longest character time last, driven through with full ticks
      set_all(16'($urandom), 16'($urandom), 24'hFFFFFF);
      for (n = 0; n < 240; n++) begin
         if (n == 40) push_req(mk(MODE_WRITE, 3'd6, 1'b0, 16'($urandom), 1'b0, 1'b0, 1'b1));
         else if (n % 8 == 0) push_req(mk(MODE_READ, 3'd2, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1));
         else if (n < 40) push_req(rand_req());
         else push_req(mk(MODE_TICK, 3'($urandom), 1'($urandom), 16'hFFFF,
                          1'($urandom), 1'($urandom), 1'b1));
      end
      wait_idle();

      $display("checked %0d requests over seven settings: %0d characters sent, %0d offers taken",
               checked_count, chars_out, offers_taken);
      $display("interrupt line restarted %0d times, %0d mismatches", restarts_seen, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
